// ===== sv/mbsp_pkg.sv =====
// Shared types and constants of the MIDI byte stream parser.
`default_nettype none
package mbsp_pkg;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int TDATA_W     = 32;

  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_QFRAME    = 8'hF1;
  localparam logic [7:0] ST_SONG_POS  = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_TUNE_REQ  = 8'hF6;
  localparam logic [7:0] ST_EOX       = 8'hF7;
  localparam logic [7:0] ST_UNDEF_RT  = 8'hFD;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;
  localparam logic [3:0] HI_SYSTEM    = 4'hF;

  typedef enum logic [2:0] {
    KIND_CHANNEL   = 3'd0,
    KIND_COMMON    = 3'd1,
    KIND_SINGLE    = 3'd2,
    KIND_SYSEX_DAT = 3'd3,
    KIND_SYSEX_END = 3'd4
  } mbsp_kind_t;

  typedef struct packed {
    mbsp_kind_t  kind;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [1:0]  data_count;
    logic        sysex_proper_end;
    logic        last_of_run;
  } mbsp_res_t;

  typedef struct packed {
    logic [7:0] running_status;
    logic [1:0] running_length;
    logic [7:0] pending_status;
    logic [1:0] pending_needed;
    logic [6:0] pending_first;
    logic [1:0] pending_have;
    logic       in_sysex;
  } mbsp_state_t;

  function automatic mbsp_res_t mk_res(mbsp_kind_t k, logic [7:0] st, logic [6:0] d1,
                                       logic [6:0] d2, logic [1:0] cnt, logic proper);
    mbsp_res_t r;
    r.kind             = k;
    r.status_byte      = st;
    r.first_data       = d1;
    r.second_data      = d2;
    r.data_count       = cnt;
    r.sysex_proper_end = proper;
    r.last_of_run      = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mbsp_decode.sv =====
// Byte decision logic: parser state and one byte in, next state and up to two results out.
`default_nettype none
module mbsp_decode (
  input  mbsp_pkg::mbsp_state_t state_i,
  input  logic [7:0]            byte_i,
  input  logic                  bend_i,
  output mbsp_pkg::mbsp_state_t state_o,
  output mbsp_pkg::mbsp_res_t   res0_o,
  output mbsp_pkg::mbsp_res_t   res1_o,
  output logic [1:0]            res_cnt_o
);
  import mbsp_pkg::*;

  mbsp_state_t s;
  mbsp_res_t   res [2];
  logic [1:0]  n;
  logic        done;
  logic [1:0]  need;
  logic [6:0]  d1;
  logic [6:0]  d2;
  logic        chan;

  always_comb begin
    s      = state_i;
    n      = 2'd0;
    done   = 1'b0;
    res[0] = '0;
    res[1] = '0;
    need   = 2'd0;
    d1     = '0;
    d2     = '0;
    chan   = 1'b0;

    if (!byte_i[7]) begin
      if (s.in_sysex) begin
        res[n[0]] = mk_res(KIND_SYSEX_DAT, ST_SYSEX, byte_i[6:0], 7'd0, 2'd1, 1'b0);
        n = n + 2'd1;
      end else begin
        // A running status data byte opens a fresh pending message first.
        if (s.pending_needed == 2'd0 && s.running_length != 2'd0) begin
          s.pending_status = s.running_status;
          s.pending_needed = s.running_length;
          s.pending_first  = '0;
          s.pending_have   = 2'd0;
        end
        if (s.pending_needed != 2'd0) begin
          if (s.pending_have == 2'd0 && s.pending_needed == 2'd2) begin
            s.pending_first = byte_i[6:0];
            s.pending_have  = 2'd1;
          end else begin
            need = s.pending_needed;
            d1   = (need == 2'd1) ? byte_i[6:0] : s.pending_first;
            d2   = (need == 2'd1) ? 7'd0 : byte_i[6:0];
            chan = (s.pending_status[7:4] != HI_SYSTEM);
            res[n[0]] = mk_res(chan ? KIND_CHANNEL : KIND_COMMON, s.pending_status,
                               d1, d2, need, 1'b0);
            n = n + 2'd1;
            if (chan) begin
              s.running_status = s.pending_status;
              s.running_length = need;
            end
            s.pending_status = '0;
            s.pending_needed = '0;
            s.pending_first  = '0;
            s.pending_have   = '0;
          end
        end
      end
    end else begin
      if (s.in_sysex) begin
        s.in_sysex = 1'b0;
        res[n[0]] = mk_res(KIND_SYSEX_END, ST_EOX, 7'd0, 7'd0, 2'd0, byte_i == ST_EOX);
        n = n + 2'd1;
        if (byte_i == ST_EOX) begin
          s.running_status = '0;
          s.running_length = '0;
          done             = 1'b1;
        end
      end
      // Any status byte aborts a partial message.
      s.pending_status = '0;
      s.pending_needed = '0;
      s.pending_first  = '0;
      s.pending_have   = '0;
      if (!done) begin
        if (byte_i[7:4] != HI_SYSTEM) begin
          s.pending_status = byte_i;
          s.pending_needed = (byte_i[7:4] inside {HI_PROGRAM, HI_PRESSURE}) ? 2'd1 : 2'd2;
        end else if (!byte_i[3]) begin
          s.running_status = '0;
          s.running_length = '0;
          case (byte_i)
            ST_SYSEX: s.in_sysex = 1'b1;
            ST_QFRAME, ST_SONG_SEL: begin
              s.pending_status = byte_i;
              s.pending_needed = 2'd1;
            end
            ST_SONG_POS: begin
              s.pending_status = byte_i;
              s.pending_needed = 2'd2;
            end
            ST_TUNE_REQ, ST_EOX: begin
              res[n[0]] = mk_res(KIND_SINGLE, byte_i, 7'd0, 7'd0, 2'd0, 1'b0);
              n = n + 2'd1;
            end
            default: ;
          endcase
        end else if (byte_i != ST_UNDEF_RT) begin
          res[n[0]] = mk_res(KIND_SINGLE, byte_i, 7'd0, 7'd0, 2'd0, 1'b0);
          n = n + 2'd1;
        end
      end
    end

    if (bend_i) begin
      if (s.in_sysex) begin
        s.in_sysex = 1'b0;
        res[n[0]] = mk_res(KIND_SYSEX_END, ST_EOX, 7'd0, 7'd0, 2'd0, 1'b0);
        n = n + 2'd1;
      end
      s.pending_status = '0;
      s.pending_needed = '0;
      s.pending_first  = '0;
      s.pending_have   = '0;
      s.running_status = '0;
      s.running_length = '0;
    end

    if (n == 2'd1) begin
      res[0].last_of_run = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last_of_run = 1'b1;
    end
  end

  assign state_o   = s;
  assign res0_o    = res[0];
  assign res1_o    = res[1];
  assign res_cnt_o = n;

endmodule
`default_nettype wire

// ===== sv/mbsp_ofifo.sv =====
// Small result queue that takes up to two results per cycle and hands out one per beat.
`default_nettype none
module mbsp_ofifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          wr_cnt,
  input  mbsp_pkg::mbsp_res_t wr0,
  input  mbsp_pkg::mbsp_res_t wr1,
  output logic                space2,
  output logic                rd_valid,
  input  logic                rd_ready,
  output mbsp_pkg::mbsp_res_t rd_data
);
  import mbsp_pkg::*;

  localparam logic [OFIFO_AW:0] DEPTH_C = (OFIFO_AW + 1)'(OFIFO_DEPTH);

  mbsp_res_t             mem [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0]   wptr_r, wptr_nxt;
  logic [OFIFO_AW-1:0]   rptr_r, rptr_nxt;
  logic [OFIFO_AW:0]     cnt_r, cnt_nxt;
  logic                  pop;

  assign rd_valid = (cnt_r != '0);
  assign pop      = rd_valid && rd_ready;
  assign space2   = (cnt_r <= DEPTH_C - (OFIFO_AW + 1)'(2));
  assign rd_data  = mem[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r + OFIFO_AW'(wr_cnt);
    rptr_nxt = rptr_r + OFIFO_AW'(pop);
    cnt_nxt  = cnt_r + (OFIFO_AW + 1)'(wr_cnt) - (OFIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem[wptr_r] <= wr0;
    end
    if (wr_cnt == 2'd2) begin
      mem[wptr_r + OFIFO_AW'(1)] <= wr1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/midi_byte_stream_parser_core.sv =====
// Top level of the MIDI byte stream parser: input register, parser state and result queue.
`default_nettype none
// Splits a raw MIDI byte stream into messages with running status. One byte is taken
// per cycle into an input register while it is empty or its byte moves on; the byte
// decision is made combinationally from that register and the parser state, and its
// results (none, one or two) are written into a four-entry result queue, so a result
// passes the input register and then the queue memory. The registered byte moves on
// whenever the queue has room for two results; the output side delivers one result
// per beat, so a byte that causes two results holds the output for two beats.
// in_tlast marks the end of a buffer and out_tlast the last result caused by a byte.
module midi_byte_stream_parser_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] midi_byte
  input  logic                           in_tlast,   // buffer_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] status_byte, [14:8] first_data, [21:15] second_data,
  // [23:22] data_count, [24] sysex_proper_end, [31:25] zero
  output logic [mbsp_pkg::TDATA_W-1:0]   out_tdata,
  output logic [2:0]                     out_tuser,  // [2:0] kind
  output logic                           out_tlast   // last_of_run
);
  import mbsp_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic        in_bend_r;
  logic        in_acc;
  logic        advance;
  logic        space2;

  mbsp_state_t state_r, state_nxt, dec_state;
  mbsp_res_t   res0, res1, rd_res;
  logic [1:0]  res_cnt;
  logic [1:0]  wr_cnt;

  assign advance    = in_vld_r && space2;
  assign in_tready  = !in_vld_r || advance;
  assign in_acc     = in_tvalid && in_tready;
  assign in_vld_nxt = in_acc ? 1'b1 : (advance ? 1'b0 : in_vld_r);
  assign state_nxt  = advance ? dec_state : state_r;
  assign wr_cnt     = advance ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      state_r  <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      state_r  <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_bend_r <= in_tlast;
    end
  end

  mbsp_decode u_decode (
    .state_i   (state_r),
    .byte_i    (in_byte_r),
    .bend_i    (in_bend_r),
    .state_o   (dec_state),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  mbsp_ofifo u_ofifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (wr_cnt),
    .wr0      (res0),
    .wr1      (res1),
    .space2   (space2),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (rd_res)
  );

  assign out_tdata = {7'd0, rd_res.sysex_proper_end, rd_res.data_count,
                      rd_res.second_data, rd_res.first_data, rd_res.status_byte};
  assign out_tuser = rd_res.kind;
  assign out_tlast = rd_res.last_of_run;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the MIDI byte stream parser core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mbsp_pkg::*;

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          PHASE_BYTES = 285;
  localparam logic [7:0]  RT_CLOCK    = 8'hF8;
  localparam logic [7:0]  RT_RESET    = 8'hFF;
  localparam logic [7:0]  ST_UNDEF_F4 = 8'hF4;
  localparam logic [7:0]  ST_UNDEF_F5 = 8'hF5;

  typedef enum int {CHECK_MODEL, EXPECT_NOTHING, EXPECT_ONE} row_check_t;

  typedef struct {
    logic [7:0] midi_byte;
    logic       buf_end;
    row_check_t check;
    mbsp_res_t  msg;
  } stim_row_t;

  typedef struct {
    logic [7:0] midi_byte;
    logic       buf_end;
  } midi_beat_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = 8'h00;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic [2:0]           out_tuser;
  logic                 out_tlast;

  always #5 clk = ~clk;

  midi_byte_stream_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Directed opening: running status, several system byte classes, sysex with a
  // proper and a cut-off end, and buffer ends with an open sysex and a partial.
  stim_row_t directed_rows [0:24] = '{
    '{8'h00,       1'b0, EXPECT_NOTHING, '0},
    '{8'h90,       1'b0, CHECK_MODEL,    '0},
    '{8'h3C,       1'b0, CHECK_MODEL,    '0},
    '{8'h7F,       1'b0, EXPECT_ONE,
      '{KIND_CHANNEL, 8'h90, 7'h3C, 7'h7F, 2'd2, 1'b0, 1'b1}},
    '{8'h40,       1'b0, CHECK_MODEL,    '0},
    '{8'h00,       1'b0, CHECK_MODEL,    '0},
    '{8'hC5,       1'b0, CHECK_MODEL,    '0},
    '{8'h7F,       1'b0, EXPECT_ONE,
      '{KIND_CHANNEL, 8'hC5, 7'h7F, 7'h00, 2'd1, 1'b0, 1'b1}},
    '{RT_CLOCK,    1'b0, EXPECT_ONE,
      '{KIND_SINGLE, RT_CLOCK, 7'h00, 7'h00, 2'd0, 1'b0, 1'b1}},
    '{8'h01,       1'b0, CHECK_MODEL,    '0},
    '{ST_UNDEF_RT, 1'b0, EXPECT_NOTHING, '0},
    '{ST_SONG_SEL, 1'b0, CHECK_MODEL,    '0},
    '{8'h55,       1'b0, CHECK_MODEL,    '0},
    '{ST_SONG_POS, 1'b0, CHECK_MODEL,    '0},
    '{8'h01,       1'b0, CHECK_MODEL,    '0},
    '{8'h7F,       1'b0, CHECK_MODEL,    '0},
    '{ST_TUNE_REQ, 1'b0, EXPECT_ONE,
      '{KIND_SINGLE, ST_TUNE_REQ, 7'h00, 7'h00, 2'd0, 1'b0, 1'b1}},
    '{ST_EOX,      1'b0, EXPECT_ONE,
      '{KIND_SINGLE, ST_EOX, 7'h00, 7'h00, 2'd0, 1'b0, 1'b1}},
    '{ST_SYSEX,    1'b0, CHECK_MODEL,    '0},
    '{8'h7F,       1'b0, EXPECT_ONE,
      '{KIND_SYSEX_DAT, ST_SYSEX, 7'h7F, 7'h00, 2'd1, 1'b0, 1'b1}},
    '{ST_EOX,      1'b0, EXPECT_ONE,
      '{KIND_SYSEX_END, ST_EOX, 7'h00, 7'h00, 2'd0, 1'b1, 1'b1}},
    '{ST_SYSEX,    1'b0, CHECK_MODEL,    '0},
    '{8'h12,       1'b1, CHECK_MODEL,    '0},
    '{8'hEF,       1'b0, CHECK_MODEL,    '0},
    '{RT_RESET,    1'b1, CHECK_MODEL,    '0}
  };

  // Parser state kept by the testbench.
  logic [7:0] run_status;
  logic [1:0] run_len;
  logic [7:0] pend_status;
  logic [1:0] pend_need;
  logic [6:0] pend_first;
  logic [1:0] pend_have;
  logic       sysex_open;

  mbsp_res_t  step_msgs [2];
  int         step_count;
  mbsp_res_t  expected_msgs [$];
  midi_beat_t byte_backlog [$];

  int          send_idle_pct;
  int          recv_stall_pct;
  int          error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent;
  int unsigned msgs_checked = 0;
  int unsigned kind_seen [5] = '{default: 0};
  logic [1:0]  gen_len;

  task automatic add_msg(input mbsp_kind_t k, input logic [7:0] st, input logic [6:0] d1,
                         input logic [6:0] d2, input logic [1:0] cnt, input logic proper);
    step_msgs[step_count] = '{k, st, d1, d2, cnt, proper, 1'b0};
    step_count++;
  endtask

  task automatic clear_pending();
    pend_status = '0;
    pend_need   = '0;
    pend_first  = '0;
    pend_have   = '0;
  endtask

  task automatic complete_message(input logic [6:0] d);
    logic is_chan;
    is_chan = pend_status[7:4] != HI_SYSTEM;
    if (pend_need == 2'd1) begin
      add_msg(is_chan ? KIND_CHANNEL : KIND_COMMON, pend_status, d, 7'h00, 2'd1, 1'b0);
    end else begin
      add_msg(is_chan ? KIND_CHANNEL : KIND_COMMON, pend_status, pend_first, d, 2'd2, 1'b0);
    end
    if (is_chan) begin
      run_status = pend_status;
      run_len    = pend_need;
    end
    clear_pending();
  endtask

  // Works out the messages that one input byte releases.
  task automatic parse_midi_byte(input logic [7:0] b, input logic brk);
    logic closed_by_eox;
    step_count    = 0;
    closed_by_eox = 1'b0;
    if (!b[7]) begin
      if (sysex_open) begin
        add_msg(KIND_SYSEX_DAT, ST_SYSEX, b[6:0], 7'h00, 2'd1, 1'b0);
      end else if (pend_need != 2'd0) begin
        if (pend_have == 2'd0 && pend_need == 2'd2) begin
          pend_first = b[6:0];
          pend_have  = 2'd1;
        end else begin
          complete_message(b[6:0]);
        end
      end else if (run_len != 2'd0) begin
        clear_pending();
        pend_status = run_status;
        pend_need   = run_len;
        if (pend_need == 2'd1) begin
          complete_message(b[6:0]);
        end else begin
          pend_first = b[6:0];
          pend_have  = 2'd1;
        end
      end
    end else begin
      if (sysex_open) begin
        sysex_open = 1'b0;
        if (b == ST_EOX) begin
          add_msg(KIND_SYSEX_END, ST_EOX, 7'h00, 7'h00, 2'd0, 1'b1);
          run_status    = '0;
          run_len       = '0;
          clear_pending();
          closed_by_eox = 1'b1;
        end else begin
          add_msg(KIND_SYSEX_END, ST_EOX, 7'h00, 7'h00, 2'd0, 1'b0);
        end
      end
      if (!closed_by_eox) begin
        clear_pending();
        if (b[7:4] != HI_SYSTEM) begin
          pend_status = b;
          pend_need   = (b[7:4] == HI_PROGRAM || b[7:4] == HI_PRESSURE) ? 2'd1 : 2'd2;
        end else if (!b[3]) begin
          run_status = '0;
          run_len    = '0;
          case (b)
            ST_SYSEX: sysex_open = 1'b1;
            ST_QFRAME, ST_SONG_SEL: begin
              pend_status = b;
              pend_need   = 2'd1;
            end
            ST_SONG_POS: begin
              pend_status = b;
              pend_need   = 2'd2;
            end
            ST_TUNE_REQ, ST_EOX: add_msg(KIND_SINGLE, b, 7'h00, 7'h00, 2'd0, 1'b0);
            default: ;
          endcase
        end else if (b != ST_UNDEF_RT) begin
          add_msg(KIND_SINGLE, b, 7'h00, 7'h00, 2'd0, 1'b0);
        end
      end
    end
    // A buffer end closes an open sysex and forgets all message state.
    if (brk) begin
      if (sysex_open) begin
        sysex_open = 1'b0;
        add_msg(KIND_SYSEX_END, ST_EOX, 7'h00, 7'h00, 2'd0, 1'b0);
      end
      clear_pending();
      run_status = '0;
      run_len    = '0;
    end
    if (step_count > 0) step_msgs[step_count-1].last_of_run = 1'b1;
  endtask

  // Drives one byte and returns once it has been taken at a clock edge.
  task automatic send_byte(input logic [7:0] b, input logic brk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= brk;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_and_predict(input logic [7:0] b, input logic brk);
    send_byte(b, brk);
    parse_midi_byte(b, brk);
    for (int i = 0; i < step_count; i++) expected_msgs.insert(expected_msgs.size(), step_msgs[i]);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    midi_beat_t nb;
    nb.midi_byte = b;
    nb.buf_end   = ($urandom_range(0, 49) == 0);
    byte_backlog.insert(byte_backlog.size(), nb);
  endtask

  // Mostly well-formed messages with random content; the rest is broken
  // sequences, interleaved realtime bytes and plain noise.
  task automatic queue_message();
    int         sel;
    int         n;
    logic [7:0] st;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      if (gen_len != 2'd0 && $urandom_range(0, 2) == 0) begin
        n = gen_len;
      end else begin
        st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
        queue_byte(st);
        n = (st[7:4] == HI_PROGRAM || st[7:4] == HI_PRESSURE) ? 1 : 2;
        gen_len = 2'(n);
      end
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 3) queue_byte(8'($urandom_range(8'hF8, 8'hFF)));
        queue_byte(8'($urandom_range(0, 127)));
      end
    end else if (sel < 60) begin
      queue_byte(ST_SYSEX);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 127)));
      if ($urandom_range(0, 4) != 0) queue_byte(ST_EOX);
      else queue_byte(8'($urandom_range(8'h80, 8'hFF)));
      gen_len = 2'd0;
    end else if (sel < 70) begin
      case ($urandom_range(0, 5))
        0: begin
          queue_byte(ST_QFRAME);
          queue_byte(8'($urandom_range(0, 127)));
        end
        1: begin
          queue_byte(ST_SONG_SEL);
          queue_byte(8'($urandom_range(0, 127)));
        end
        2: begin
          queue_byte(ST_SONG_POS);
          queue_byte(8'($urandom_range(0, 127)));
          queue_byte(8'($urandom_range(0, 127)));
        end
        3: queue_byte(ST_TUNE_REQ);
        4: queue_byte(ST_EOX);
        default: queue_byte($urandom_range(0, 1) ? ST_UNDEF_F4 : ST_UNDEF_F5);
      endcase
      gen_len = 2'd0;
    end else if (sel < 78) begin
      queue_byte(8'($urandom_range(8'hF8, 8'hFF)));
    end else if (sel < 88) begin
      // A two-byte message that stops after its first data byte.
      queue_byte({1'b1, 3'($urandom_range(0, 3)), 4'($urandom)});
      queue_byte(8'($urandom_range(0, 127)));
    end else begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  function automatic string show_msg(input mbsp_res_t m);
    return $sformatf("kind %0d status %02h d1 %02h d2 %02h count %0d proper %0b last %0b",
                     m.kind, m.status_byte, m.first_data, m.second_data, m.data_count,
                     m.sysex_proper_end, m.last_of_run);
  endfunction

  // Output side: checks each beat taken and decides the next stall.
  always @(posedge clk) begin
    mbsp_res_t got;
    mbsp_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{mbsp_kind_t'(out_tuser), out_tdata[7:0], out_tdata[14:8], out_tdata[21:15],
              out_tdata[23:22], out_tdata[24], out_tlast};
      msgs_checked++;
      if (out_tuser < 3'd5) kind_seen[out_tuser]++;
      if (expected_msgs.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got %s", $time, show_msg(got));
        error_count++;
      end else begin
        want = expected_msgs.pop_front();
        if (got !== want || out_tdata[TDATA_W-1:25] !== '0) begin
          $display("%0t: mismatch: expected %s, padding 0", $time, show_msg(want));
          $display("%0t:           got      %s, padding %0h", $time, show_msg(got),
                   out_tdata[TDATA_W-1:25]);
          error_count++;
        end
      end
    end
    out_tready <= $urandom_range(0, 99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $time, expected_msgs.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int phase_sent;
    midi_beat_t nb;
    run_status     = '0;
    run_len        = '0;
    clear_pending();
    sysex_open     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bytes_sent     = 0;
    gen_len        = 2'd0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].midi_byte, directed_rows[i].buf_end);
      parse_midi_byte(directed_rows[i].midi_byte, directed_rows[i].buf_end);
      case (directed_rows[i].check)
        CHECK_MODEL:
          for (int j = 0; j < step_count; j++)
            expected_msgs.insert(expected_msgs.size(), step_msgs[j]);
        EXPECT_ONE: expected_msgs.insert(expected_msgs.size(), directed_rows[i].msg);
        default: ;
      endcase
    end

    // Random part in four flow-control phases: free running, slow sender,
    // slow receiver and light idling on both sides.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (ph == 2) begin
        // Let the output side drain completely before going on.
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_msgs.size() != 0) @(posedge clk);
      end
      phase_sent = 0;
      while (phase_sent < PHASE_BYTES) begin
        if (byte_backlog.size() == 0) queue_message();
        nb = byte_backlog.pop_front();
        send_and_predict(nb.midi_byte, nb.buf_end);
        phase_sent++;
      end
    end
    while (byte_backlog.size() != 0) begin
      nb = byte_backlog.pop_front();
      send_and_predict(nb.midi_byte, nb.buf_end);
    end
    in_tvalid <= 1'b0;

    while (expected_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d bytes under four flow-control phases; checked %0d result beats.",
             bytes_sent, msgs_checked);
    $display("Beats by kind: channel %0d, common %0d, single %0d, sysex data %0d, sysex end %0d.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
